// ===== rtl/jmsv_pkg.sv =====
`default_nettype none
package jmsv_pkg;
    typedef enum logic [31:0] {
        S_START      = 32'h0000_0001,
        S_START_WS   = 32'h0000_0002,
        S_TOP_FIRST  = 32'h0000_0004,
        S_TOP_KEY    = 32'h0000_0008,
        S_TOP_COLON  = 32'h0000_0010,
        S_TOP_VAL    = 32'h0000_0020,
        S_TARGET     = 32'h0000_0040,
        S_TOP_AFTER  = 32'h0000_0080,
        S_TOP_NEXT   = 32'h0000_0100,
        S_DONE       = 32'h0000_0200,
        S_VALUE      = 32'h0000_0400,
        S_ARR_FIRST  = 32'h0000_0800,
        S_OBJ_FIRST  = 32'h0000_1000,
        S_OBJ_KEY    = 32'h0000_2000,
        S_KEY_ESC    = 32'h0000_4000,
        S_KEY_HEX    = 32'h0000_8000,
        S_OBJ_COLON  = 32'h0001_0000,
        S_OBJ_AFTER  = 32'h0002_0000,
        S_OBJ_NEXT   = 32'h0004_0000,
        S_ARR_AFTER  = 32'h0008_0000,
        S_STR        = 32'h0010_0000,
        S_STR_ESC    = 32'h0020_0000,
        S_STR_HEX    = 32'h0040_0000,
        S_LIT        = 32'h0080_0000,
        S_N_MINUS    = 32'h0100_0000,
        S_N_ZERO     = 32'h0200_0000,
        S_N_INT      = 32'h0400_0000,
        S_N_DOT      = 32'h0800_0000,
        S_N_FRAC     = 32'h1000_0000,
        S_N_E        = 32'h2000_0000,
        S_N_ESIGN    = 32'h4000_0000,
        S_N_EXP      = 32'h8000_0000
    } t_state;

    // byte classes computed in the front stage
    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       last;
        logic       ws;
        logic       dig;
        logic       hex;
        logic       esc;
        logic       ctl;
    } t_item;

    typedef struct packed {
        logic       cap_valid;
        logic [1:0] cap_target;
        logic [7:0] cap_byte;
        logic       done;
        logic       accepted;
        logic [3:0] mask;
    } t_result;

    localparam int KEY_NAME_LEN = 24;
    localparam logic [4:0] KEY_LEN [4] = '{5'd7, 5'd2, 5'd8, 5'd21};
    localparam logic [7:0] LIT_DELIM = 8'h20;

    function automatic logic [7:0] key_char(input logic [1:0] k, input logic [4:0] p);
        logic [8*KEY_NAME_LEN-1:0] s;
        begin
            unique case (k)
                2'd0: s = {"pd_kind", {17{8'h00}}};
                2'd1: s = {"id", {22{8'h00}}};
                2'd2: s = {"geometry", {16{8'h00}}};
                default: s = {"source_filenum_symbol", {3{8'h00}}};
            endcase
            key_char = s[8*(KEY_NAME_LEN-1-int'(p)) +: 8];
        end
    endfunction

    function automatic logic [7:0] lit_char(input logic [3:0] p);
        logic [8*13-1:0] s;
        begin
            s = "truefalsenull";
            lit_char = (p < 4'd13) ? s[8*(12-int'(p)) +: 8] : 8'h00;
        end
    endfunction
endpackage
`default_nettype wire

// ===== rtl/jmsv_if.sv =====
`default_nettype none
interface jmsv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       last;
    modport source (output valid, data_byte, byte_present, last, input ready);
    modport sink (input valid, data_byte, byte_present, last, output ready);
endinterface

interface jmsv_out_if;
    logic       valid;
    logic       ready;
    logic       capture_valid;
    logic [1:0] capture_target;
    logic [7:0] capture_byte;
    logic       done_res;
    logic       accepted;
    logic [3:0] present_mask;
    modport source (output valid, capture_valid, capture_target, capture_byte, done_res,
                    accepted, present_mask, input ready);
    modport sink (input valid, capture_valid, capture_target, capture_byte, done_res,
                  accepted, present_mask, output ready);
endinterface
`default_nettype wire

// ===== rtl/jmsv_front.sv =====
`default_nettype none
module jmsv_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    jmsv_in_if.sink            in_ch,
    output jmsv_pkg::t_item    o_item,
    output logic               o_valid,
    input  wire logic          i_ready
);
    import jmsv_pkg::*;

    logic [7:0] c;
    assign c = in_ch.data_byte;
    assign in_ch.ready = i_ready;
    assign o_valid     = in_ch.valid;

    always_comb begin
        o_item.data    = c;
        o_item.present = in_ch.byte_present;
        o_item.last    = in_ch.last;
        o_item.ws      = (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
        o_item.dig     = (c >= "0" && c <= "9");
        o_item.hex     = o_item.dig || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
        o_item.esc     = (c == "\"") || (c == "\\") || (c == "/") || (c == "b")
                      || (c == "f") || (c == "n") || (c == "r") || (c == "t");
        o_item.ctl     = (c < LIT_DELIM);
    end
endmodule
`default_nettype wire

// ===== rtl/jmsv_queue.sv =====
`default_nettype none
module jmsv_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire jmsv_pkg::t_item i_item,
    input  wire logic          i_valid,
    output logic               o_ready,
    output jmsv_pkg::t_item    o_item,
    output logic               o_valid,
    input  wire logic          i_ready
);
    import jmsv_pkg::*;

    t_item      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

// ===== rtl/jmsv_back.sv =====
`default_nettype none
module jmsv_back #(
    parameter int MAX_DEPTH  = 64,
    parameter int KEY_CAP    = 64,
    parameter int KIND_CAP   = 32,
    parameter int ID_CAP     = 64,
    parameter int PATH_CAP   = 256,
    parameter int SYMBOL_CAP = 64
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire jmsv_pkg::t_item i_item,
    input  wire logic            i_valid,
    output logic                 o_ready,
    jmsv_out_if.source           out_ch
);
    import jmsv_pkg::*;

    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int MAXCAP = (KEY_CAP > PATH_CAP) ? KEY_CAP : PATH_CAP;
    localparam int LW = $clog2(MAXCAP + 1);

    t_state             r_st, n_st;
    logic [MAX_DEPTH-1:0] r_stk, n_stk;
    logic [DW-1:0]      r_dep, n_dep;
    logic [LW-1:0]      r_len, n_len;
    logic [3:0]         r_km, n_km;
    logic [2:0]         r_hex, n_hex;
    logic [3:0]         r_lit, n_lit;
    logic [3:0]         r_pf, n_pf;
    logic               r_fail, n_fail;
    t_result            r_out, n_out;
    logic               r_ov;

    logic               take;
    logic [7:0]         c;
    logic [1:0]         tgt;
    logic [LW-1:0]      cap;

    assign o_ready = !r_ov || out_ch.ready;
    assign take    = i_valid && o_ready;
    assign c       = i_item.data;

    always_comb begin
        tgt = r_km[0] ? 2'd0 : r_km[1] ? 2'd1 : r_km[2] ? 2'd2 : r_km[3] ? 2'd3 : 2'd0;
        case (tgt)
            2'd0: cap = LW'(KIND_CAP);
            2'd1: cap = LW'(ID_CAP);
            2'd2: cap = LW'(PATH_CAP);
            default: cap = LW'(SYMBOL_CAP);
        endcase
    end

    // after a value: pick the state of the enclosing container
    function automatic t_state after_of(input logic [DW-1:0] d,
                                        input logic [MAX_DEPTH-1:0] s);
        if (d <= DW'(1) || d > DW'(MAX_DEPTH)) return S_TOP_AFTER;
        return s[AW'(d - DW'(1))] ? S_OBJ_AFTER : S_ARR_AFTER;
    endfunction

    always_comb begin
        logic [3:0] live;
        logic       sv_fail;
        logic       num_end;
        n_st = r_st; n_stk = r_stk; n_dep = r_dep; n_len = r_len; n_km = r_km;
        n_hex = r_hex; n_lit = r_lit; n_pf = r_pf; n_fail = r_fail;
        n_out = '0;
        live = 4'd0;
        sv_fail = 1'b0;
        num_end = 1'b0;
        if (i_item.present && !r_fail) begin
            unique case (r_st)
                S_START, S_START_WS: begin
                    if (i_item.ws) n_st = S_START_WS;
                    else if (c == "{") begin
                        n_stk[0] = 1'b1; n_dep = DW'(1); n_st = S_TOP_FIRST;
                    end else n_fail = 1'b1;
                end
                S_TOP_FIRST, S_TOP_AFTER, S_TOP_NEXT: begin
                    if (i_item.ws) ;
                    else if (c == "}" && r_st != S_TOP_NEXT) begin
                        n_dep = '0; n_st = S_DONE;
                    end else if (c == "," && r_st == S_TOP_AFTER) n_st = S_TOP_NEXT;
                    else if (c == "\"" && r_st != S_TOP_AFTER) begin
                        n_len = '0; n_km = 4'hF; n_st = S_TOP_KEY;
                    end else n_fail = 1'b1;
                end
                S_TOP_KEY: begin
                    if (c == "\"") begin
                        if (r_len < LW'(KEY_CAP))
                            for (int i = 0; i < 4; i++)
                                if (r_km[i] && r_len == LW'(KEY_LEN[i])) live = 4'(1 << i);
                        n_km = live;
                        if ((live & r_pf) != 4'd0) n_fail = 1'b1;
                        else n_st = S_TOP_COLON;
                    end else if (c == "\\" || i_item.ctl) n_fail = 1'b1;
                    else begin
                        for (int i = 0; i < 4; i++)
                            if (r_km[i] && r_len < LW'(KEY_LEN[i])
                                && key_char(2'(i), r_len[4:0]) == c) live[i] = 1'b1;
                        n_km = live;
                        if (r_len < LW'(MAXCAP)) n_len = r_len + LW'(1);
                    end
                end
                S_TOP_COLON, S_OBJ_COLON: begin
                    if (i_item.ws) ;
                    else if (c == ":") n_st = (r_st == S_TOP_COLON) ? S_TOP_VAL : S_VALUE;
                    else n_fail = 1'b1;
                end
                S_TOP_VAL: begin
                    if (i_item.ws) ;
                    else if (r_km == 4'd0) sv_fail = 1'b1;
                    else if (c == "\"") begin n_len = '0; n_st = S_TARGET; end
                    else n_fail = 1'b1;
                end
                S_TARGET: begin
                    if (c == "\"") begin
                        n_pf = r_pf | r_km; n_st = S_TOP_AFTER;
                    end else if (c == "\\" || i_item.ctl || r_len + LW'(1) >= cap)
                        n_fail = 1'b1;
                    else begin
                        n_len = r_len + LW'(1);
                        n_out.cap_valid = 1'b1; n_out.cap_target = tgt; n_out.cap_byte = c;
                    end
                end
                S_DONE: if (!i_item.ws) n_fail = 1'b1;
                S_VALUE: if (!i_item.ws) sv_fail = 1'b1;
                S_ARR_FIRST: begin
                    if (i_item.ws) ;
                    else if (c == "]") begin
                        n_dep = r_dep - DW'(1); n_st = after_of(n_dep, r_stk);
                    end else sv_fail = 1'b1;
                end
                S_OBJ_FIRST, S_OBJ_NEXT: begin
                    if (i_item.ws) ;
                    else if (c == "}" && r_st == S_OBJ_FIRST) begin
                        n_dep = r_dep - DW'(1); n_st = after_of(n_dep, r_stk);
                    end else if (c == "\"") n_st = S_OBJ_KEY;
                    else n_fail = 1'b1;
                end
                S_OBJ_KEY, S_STR: begin
                    if (c == "\"") n_st = (r_st == S_OBJ_KEY) ? S_OBJ_COLON
                                                             : after_of(r_dep, r_stk);
                    else if (c == "\\") n_st = (r_st == S_OBJ_KEY) ? S_KEY_ESC : S_STR_ESC;
                    else if (i_item.ctl) n_fail = 1'b1;
                end
                S_KEY_ESC, S_STR_ESC: begin
                    if (c == "u") begin
                        n_hex = '0; n_st = (r_st == S_KEY_ESC) ? S_KEY_HEX : S_STR_HEX;
                    end else if (i_item.esc) n_st = (r_st == S_KEY_ESC) ? S_OBJ_KEY : S_STR;
                    else n_fail = 1'b1;
                end
                S_KEY_HEX, S_STR_HEX: begin
                    if (!i_item.hex) n_fail = 1'b1;
                    else begin
                        n_hex = r_hex + 3'd1;
                        if (n_hex >= 3'd4) n_st = (r_st == S_KEY_HEX) ? S_OBJ_KEY : S_STR;
                    end
                end
                S_OBJ_AFTER, S_ARR_AFTER: begin
                    if (i_item.ws) ;
                    else if (c == ",") n_st = (r_st == S_OBJ_AFTER) ? S_OBJ_NEXT : S_VALUE;
                    else if (c == ((r_st == S_OBJ_AFTER) ? "}" : "]")) begin
                        n_dep = r_dep - DW'(1); n_st = after_of(n_dep, r_stk);
                    end else n_fail = 1'b1;
                end
                S_LIT: begin
                    if (r_lit < 4'd13 && c == lit_char(r_lit)) begin
                        n_lit = r_lit + 4'd1;
                        if (n_lit == 4'd4 || n_lit == 4'd9 || n_lit == 4'd13)
                            n_st = after_of(r_dep, r_stk);
                    end else n_fail = 1'b1;
                end
                S_N_MINUS: begin
                    if (c == "0") n_st = S_N_ZERO;
                    else if (i_item.dig) n_st = S_N_INT;
                    else n_fail = 1'b1;
                end
                S_N_ZERO, S_N_INT: begin
                    if (i_item.dig) begin if (r_st == S_N_ZERO) n_fail = 1'b1; end
                    else if (c == ".") n_st = S_N_DOT;
                    else if (c == "e" || c == "E") n_st = S_N_E;
                    else num_end = 1'b1;
                end
                S_N_DOT: if (i_item.dig) n_st = S_N_FRAC; else n_fail = 1'b1;
                S_N_FRAC: begin
                    if (i_item.dig) ;
                    else if (c == "e" || c == "E") n_st = S_N_E;
                    else num_end = 1'b1;
                end
                S_N_E: begin
                    if (c == "+" || c == "-") n_st = S_N_ESIGN;
                    else if (i_item.dig) n_st = S_N_EXP;
                    else n_fail = 1'b1;
                end
                S_N_ESIGN: if (i_item.dig) n_st = S_N_EXP; else n_fail = 1'b1;
                S_N_EXP: if (!i_item.dig) num_end = 1'b1;
                default: n_fail = 1'b1;
            endcase

            // number ended: reprocess the byte in the enclosing container
            if (num_end) begin
                n_st = after_of(r_dep, r_stk);
                if (i_item.ws) ;
                else if (n_st == S_TOP_AFTER) begin
                    if (c == "}") begin n_dep = '0; n_st = S_DONE; end
                    else if (c == ",") n_st = S_TOP_NEXT;
                    else n_fail = 1'b1;
                end else if (c == ",") n_st = (n_st == S_OBJ_AFTER) ? S_OBJ_NEXT : S_VALUE;
                else if (c == ((n_st == S_OBJ_AFTER) ? "}" : "]")) begin
                    n_dep = r_dep - DW'(1); n_st = after_of(n_dep, r_stk);
                end else n_fail = 1'b1;
            end

            // start of a value
            if (sv_fail) begin
                if (r_dep >= DW'(MAX_DEPTH)) n_fail = 1'b1;
                else if (c == "\"") n_st = S_STR;
                else if (c == "{" || c == "[") begin
                    n_stk[AW'(r_dep)] = (c == "{");
                    n_dep = r_dep + DW'(1);
                    n_st = (c == "{") ? S_OBJ_FIRST : S_ARR_FIRST;
                end else if (c == "-") n_st = S_N_MINUS;
                else if (c == "0") n_st = S_N_ZERO;
                else if (i_item.dig) n_st = S_N_INT;
                else if (c == "t") begin n_lit = 4'd1; n_st = S_LIT; end
                else if (c == "f") begin n_lit = 4'd5; n_st = S_LIT; end
                else if (c == "n") begin n_lit = 4'd10; n_st = S_LIT; end
                else n_fail = 1'b1;
            end
        end
        n_out.mask = n_pf;
        if (i_item.last) begin
            n_out.done = 1'b1;
            n_out.accepted = !n_fail && ((n_st == S_DONE) || (!i_item.present && r_st == S_START));
            n_st = S_START; n_stk = '0; n_dep = '0; n_len = '0; n_km = 4'hF;
            n_hex = '0; n_lit = '0; n_pf = '0; n_fail = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_START; r_stk <= '0; r_dep <= '0; r_len <= '0; r_km <= 4'hF;
            r_hex <= '0; r_lit <= '0; r_pf <= '0; r_fail <= 1'b0; r_ov <= 1'b0;
        end else begin
            if (take) begin
                r_st <= n_st; r_stk <= n_stk; r_dep <= n_dep; r_len <= n_len;
                r_km <= n_km; r_hex <= n_hex; r_lit <= n_lit; r_pf <= n_pf;
                r_fail <= n_fail;
            end
            if (take) r_ov <= 1'b1;
            else if (out_ch.ready) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) r_out <= n_out;
    end

    assign out_ch.valid          = r_ov;
    assign out_ch.capture_valid  = r_out.cap_valid;
    assign out_ch.capture_target = r_out.cap_target;
    assign out_ch.capture_byte   = r_out.cap_byte;
    assign out_ch.done_res       = r_out.done;
    assign out_ch.accepted       = r_out.accepted;
    assign out_ch.present_mask   = r_out.mask;
endmodule
`default_nettype wire

// ===== rtl/json_manifest_stream_validator.sv =====
`default_nettype none
// Streaming JSON manifest validator.
// Input channel i_in: one request per manifest byte (data_byte, byte_present, last).
// Output channel o_out: exactly one result per input request, in order, carrying
// the captured value byte of a recognized top-level key, the running present mask,
// and on the last request done_res with the accept verdict.
// A front stage classifies each byte, a two-entry queue decouples it from the back
// stage, whose parse state machine and container stack handle one byte a cycle
// while the output is not stalled, sustaining one byte per cycle. Each accepted
// byte is registered in a queue entry, then in the back stage output register.
// When the receiver stalls, the result holds in the output register, the queue
// absorbs up to two more bytes, then ready drops.
// Reset (synchronous, active low) empties the queue and returns the parser to
// the start of a manifest; the item with last set also does so after its result.
// The stack is held in flip-flops, so no clearing pass is needed.
module json_manifest_stream_validator #(
    parameter int MAX_DEPTH  = 64,
    parameter int KEY_CAP    = 64,
    parameter int KIND_CAP   = 32,
    parameter int ID_CAP     = 64,
    parameter int PATH_CAP   = 256,
    parameter int SYMBOL_CAP = 64
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    jmsv_in_if.sink    i_in,
    jmsv_out_if.source o_out
);
    import jmsv_pkg::*;

    t_item f_item, q_item;
    logic  f_valid, f_ready, q_valid, q_ready;

    jmsv_front u_front (
        .i_clk, .i_rst_n, .in_ch(i_in), .o_item(f_item), .o_valid(f_valid),
        .i_ready(f_ready)
    );

    jmsv_queue u_queue (
        .i_clk, .i_rst_n, .i_item(f_item), .i_valid(f_valid), .o_ready(f_ready),
        .o_item(q_item), .o_valid(q_valid), .i_ready(q_ready)
    );

    jmsv_back #(
        .MAX_DEPTH(MAX_DEPTH), .KEY_CAP(KEY_CAP), .KIND_CAP(KIND_CAP),
        .ID_CAP(ID_CAP), .PATH_CAP(PATH_CAP), .SYMBOL_CAP(SYMBOL_CAP)
    ) u_back (
        .i_clk, .i_rst_n, .i_item(q_item), .i_valid(q_valid), .o_ready(q_ready),
        .out_ch(o_out)
    );
endmodule
`default_nettype wire

// ===== bench/tb_json_manifest_stream_validator.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_json_manifest_stream_validator;
    import jmsv_pkg::*;

    localparam int DEPTH_MAX = 64;
    localparam int KEY_LIMIT = 64;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TARGET_CAP [4] = '{32, 64, 256, 64};
    localparam logic [7:0] QUOTE = 8'h22;
    localparam logic [7:0] BSLASH = 8'h5C;

    typedef struct {
        logic [7:0] data;
        logic       present;
        logic       last;
        bit         typed;
        t_result    exp;
    } t_request;

    logic i_clk;
    logic i_rst_n;
    jmsv_in_if  in_ch ();
    jmsv_out_if out_ch ();

    json_manifest_stream_validator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // parser mirror
    string      key_name [4] = '{"pd_kind", "id", "geometry", "source_filenum_symbol"};
    string      lit_text = "truefalsenull";
    t_state     mode;
    bit         ctx [DEPTH_MAX];
    int         depth;
    int         str_len;
    logic [3:0] key_live;
    int         hex_seen;
    int         lit_pos;
    logic [3:0] seen_mask;
    bit         broken;
    bit         cap_v;
    logic [1:0] cap_t;
    logic [7:0] cap_b;

    function automatic bit is_space(logic [7:0] c);
        return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_hexch(logic [7:0] c);
        return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic bit is_escch(logic [7:0] c);
        return c == QUOTE || c == BSLASH || c == "/" || c == "b" || c == "f"
            || c == "n" || c == "r" || c == "t";
    endfunction

    function automatic void clear_parser();
        mode = S_START;
        foreach (ctx[i]) ctx[i] = 1'b0;
        depth = 0;
        str_len = 0;
        key_live = 4'hF;
        hex_seen = 0;
        lit_pos = 0;
        seen_mask = 4'h0;
        broken = 1'b0;
    endfunction

    function automatic void finish_value();
        if (depth <= 1 || depth > DEPTH_MAX) begin
            mode = S_TOP_AFTER;
        end else begin
            mode = ctx[depth-1] ? S_OBJ_AFTER : S_ARR_AFTER;
        end
    endfunction

    function automatic void close_level();
        if (depth > 0) depth--;
        finish_value();
    endfunction

    function automatic void open_value(logic [7:0] c);
        if (depth >= DEPTH_MAX) begin
            broken = 1'b1;
        end else if (c == QUOTE) begin
            mode = S_STR;
        end else if (c == "{" || c == "[") begin
            ctx[depth] = (c == "{");
            depth++;
            mode = (c == "{") ? S_OBJ_FIRST : S_ARR_FIRST;
        end else if (c == "-") begin
            mode = S_N_MINUS;
        end else if (c == "0") begin
            mode = S_N_ZERO;
        end else if (c >= "1" && c <= "9") begin
            mode = S_N_INT;
        end else if (c == "t") begin
            lit_pos = 1; mode = S_LIT;
        end else if (c == "f") begin
            lit_pos = 5; mode = S_LIT;
        end else if (c == "n") begin
            lit_pos = 10; mode = S_LIT;
        end else begin
            broken = 1'b1;
        end
    endfunction

    function automatic void start_top_key();
        str_len = 0;
        key_live = 4'hF;
        mode = S_TOP_KEY;
    endfunction

    function automatic void top_key_char(logic [7:0] c);
        logic [3:0] live;
        live = 4'h0;
        if (c == QUOTE) begin
            if (str_len < KEY_LIMIT) begin
                for (int i = 0; i < 4; i++) begin
                    if (key_live[i] && str_len == key_name[i].len()) live = 4'h1 << i;
                end
            end
            key_live = live;
            if (live & seen_mask) broken = 1'b1;
            else mode = S_TOP_COLON;
        end else if (c == BSLASH || c < 8'h20) begin
            broken = 1'b1;
        end else begin
            for (int i = 0; i < 4; i++) begin
                if (key_live[i] && str_len < key_name[i].len() && key_name[i][str_len] == c)
                    live[i] = 1'b1;
            end
            key_live = live;
            if (str_len < 65535) str_len++;
        end
    endfunction

    function automatic void target_char(logic [7:0] c);
        int t;
        t = 0;
        for (int i = 3; i >= 0; i--) begin
            if (key_live[i]) t = i;
        end
        if (c == QUOTE) begin
            seen_mask |= key_live;
            mode = S_TOP_AFTER;
        end else if (c == BSLASH || c < 8'h20 || str_len + 1 >= TARGET_CAP[t]) begin
            broken = 1'b1;
        end else begin
            str_len++;
            cap_v = 1'b1;
            cap_t = t[1:0];
            cap_b = c;
        end
    endfunction

    function automatic void parse_byte(logic [7:0] c);
        bit again;
        again = 1'b1;
        while (again && !broken) begin
            again = 1'b0;
            case (mode)
                S_START, S_START_WS: begin
                    if (is_space(c)) mode = S_START_WS;
                    else if (c == "{") begin
                        ctx[0] = 1'b1; depth = 1; mode = S_TOP_FIRST;
                    end else broken = 1'b1;
                end
                S_TOP_FIRST: if (!is_space(c)) begin
                    if (c == "}") begin depth = 0; mode = S_DONE; end
                    else if (c == QUOTE) start_top_key();
                    else broken = 1'b1;
                end
                S_TOP_KEY: top_key_char(c);
                S_TOP_COLON: if (!is_space(c)) begin
                    if (c == ":") mode = S_TOP_VAL; else broken = 1'b1;
                end
                S_TOP_VAL: if (!is_space(c)) begin
                    if (key_live == 4'h0) open_value(c);
                    else if (c == QUOTE) begin str_len = 0; mode = S_TARGET; end
                    else broken = 1'b1;
                end
                S_TARGET: target_char(c);
                S_TOP_AFTER: if (!is_space(c)) begin
                    if (c == "}") begin depth = 0; mode = S_DONE; end
                    else if (c == ",") mode = S_TOP_NEXT;
                    else broken = 1'b1;
                end
                S_TOP_NEXT: if (!is_space(c)) begin
                    if (c == QUOTE) start_top_key(); else broken = 1'b1;
                end
                S_DONE: if (!is_space(c)) broken = 1'b1;
                S_VALUE: if (!is_space(c)) open_value(c);
                S_ARR_FIRST: if (!is_space(c)) begin
                    if (c == "]") close_level(); else open_value(c);
                end
                S_OBJ_FIRST, S_OBJ_NEXT: if (!is_space(c)) begin
                    if (c == "}" && mode == S_OBJ_FIRST) close_level();
                    else if (c == QUOTE) mode = S_OBJ_KEY;
                    else broken = 1'b1;
                end
                S_OBJ_KEY, S_STR: begin
                    if (c == QUOTE) begin
                        if (mode == S_OBJ_KEY) mode = S_OBJ_COLON; else finish_value();
                    end else if (c == BSLASH) begin
                        mode = (mode == S_OBJ_KEY) ? S_KEY_ESC : S_STR_ESC;
                    end else if (c < 8'h20) broken = 1'b1;
                end
                S_KEY_ESC, S_STR_ESC: begin
                    if (c == "u") begin
                        hex_seen = 0;
                        mode = (mode == S_KEY_ESC) ? S_KEY_HEX : S_STR_HEX;
                    end else if (is_escch(c)) begin
                        mode = (mode == S_KEY_ESC) ? S_OBJ_KEY : S_STR;
                    end else broken = 1'b1;
                end
                S_KEY_HEX, S_STR_HEX: begin
                    if (!is_hexch(c)) broken = 1'b1;
                    else begin
                        hex_seen++;
                        if (hex_seen >= 4) mode = (mode == S_KEY_HEX) ? S_OBJ_KEY : S_STR;
                    end
                end
                S_OBJ_COLON: if (!is_space(c)) begin
                    if (c == ":") mode = S_VALUE; else broken = 1'b1;
                end
                S_OBJ_AFTER, S_ARR_AFTER: if (!is_space(c)) begin
                    if (c == ",") mode = (mode == S_OBJ_AFTER) ? S_OBJ_NEXT : S_VALUE;
                    else if (c == ((mode == S_OBJ_AFTER) ? "}" : "]")) close_level();
                    else broken = 1'b1;
                end
                S_LIT: begin
                    if (lit_pos < 13 && c == lit_text[lit_pos]) begin
                        lit_pos++;
                        if (lit_pos == 4 || lit_pos == 9 || lit_pos == 13) finish_value();
                    end else broken = 1'b1;
                end
                S_N_MINUS: begin
                    if (c == "0") mode = S_N_ZERO;
                    else if (c >= "1" && c <= "9") mode = S_N_INT;
                    else broken = 1'b1;
                end
                S_N_ZERO, S_N_INT: begin
                    if (is_digit(c)) begin
                        if (mode == S_N_ZERO) broken = 1'b1;
                    end else if (c == ".") mode = S_N_DOT;
                    else if (c == "e" || c == "E") mode = S_N_E;
                    else begin finish_value(); again = 1'b1; end
                end
                S_N_DOT: if (is_digit(c)) mode = S_N_FRAC; else broken = 1'b1;
                S_N_FRAC: if (!is_digit(c)) begin
                    if (c == "e" || c == "E") mode = S_N_E;
                    else begin finish_value(); again = 1'b1; end
                end
                S_N_E: begin
                    if (c == "+" || c == "-") mode = S_N_ESIGN;
                    else if (is_digit(c)) mode = S_N_EXP;
                    else broken = 1'b1;
                end
                S_N_ESIGN: if (is_digit(c)) mode = S_N_EXP; else broken = 1'b1;
                S_N_EXP: if (!is_digit(c)) begin finish_value(); again = 1'b1; end
                default: broken = 1'b1;
            endcase
        end
    endfunction

    function automatic t_result validate_step(logic [7:0] c, logic present, logic last);
        t_result r;
        bit empty_ok;
        empty_ok = (mode == S_START);
        cap_v = 1'b0;
        cap_t = 2'd0;
        cap_b = 8'h00;
        if (present && !broken) parse_byte(c);
        r.cap_valid = cap_v;
        r.cap_target = cap_t;
        r.cap_byte = cap_b;
        r.done = last;
        r.accepted = last && !broken && (mode == S_DONE || (!present && empty_ok));
        r.mask = seen_mask;
        if (last) clear_parser();
        return r;
    endfunction

    // stimulus
    t_request   requests[$];
    t_request   issued[$];
    t_result    expected_results[$];
    logic [7:0] text[$];
    int         errors;
    int         results_seen;
    bit         calm;

    function automatic t_result verdict(logic [3:0] mask, logic ok);
        t_result r;
        r = '0;
        r.done = 1'b1;
        r.accepted = ok;
        r.mask = mask;
        return r;
    endfunction

    function automatic void add_request(logic [7:0] d, logic p, logic l, bit typed = 1'b0,
                                        t_result e = '0);
        t_request q;
        q.data = d;
        q.present = p;
        q.last = l;
        q.typed = typed;
        q.exp = e;
        requests.push_back(q);
    endfunction

    function automatic void put(string s);
        for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
    endfunction

    function automatic void put_space();
        logic [7:0] spaces [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
        if ($urandom_range(0, 3) == 0) text.push_back(spaces[$urandom_range(0, 5)]);
    endfunction

    function automatic void put_chars(int n, bit allow_esc);
        logic [7:0] c;
        for (int i = 0; i < n; i++) begin
            if (allow_esc && $urandom_range(0, 9) == 0) begin
                if ($urandom_range(0, 1) == 0) put("\\n");
                else put("\\u0aF9");
            end else begin
                do c = 8'($urandom_range(8'h20, 8'h7E)); while (c == QUOTE || c == BSLASH);
                text.push_back(c);
            end
        end
    endfunction

    function automatic void put_number();
        if ($urandom_range(0, 2) == 0) put("-");
        if ($urandom_range(0, 2) == 0) put("0");
        else begin
            text.push_back(8'($urandom_range("1", "9")));
            repeat ($urandom_range(0, 3)) text.push_back(8'($urandom_range("0", "9")));
        end
        if ($urandom_range(0, 2) == 0) begin
            put(".");
            repeat ($urandom_range(1, 3)) text.push_back(8'($urandom_range("0", "9")));
        end
        if ($urandom_range(0, 3) == 0) begin
            put($urandom_range(0, 1) ? "e" : "E");
            case ($urandom_range(0, 2))
                0: put("+");
                1: put("-");
                default: ;
            endcase
            repeat ($urandom_range(1, 2)) text.push_back(8'($urandom_range("0", "9")));
        end
    endfunction

    function automatic void put_value(int lvl);
        int n;
        case ($urandom_range(0, 9))
            0, 1, 2: begin put("\""); put_chars($urandom_range(0, 6), 1'b1); put("\""); end
            3, 4: put_number();
            5: case ($urandom_range(0, 2))
                0: put("true");
                1: put("false");
                default: put("null");
            endcase
            6, 7: if (lvl < 3) begin
                put("["); put_space();
                n = $urandom_range(0, 3);
                for (int i = 0; i < n; i++) begin
                    if (i > 0) put(",");
                    put_space(); put_value(lvl + 1); put_space();
                end
                put("]");
            end else put_number();
            default: if (lvl < 3) begin
                put("{"); put_space();
                n = $urandom_range(0, 3);
                for (int i = 0; i < n; i++) begin
                    if (i > 0) put(",");
                    put_space(); put("\""); put_chars($urandom_range(0, 4), 1'b1); put("\"");
                    put_space(); put(":"); put_space(); put_value(lvl + 1); put_space();
                end
                put("}");
            end else put("null");
        endcase
    endfunction

    function automatic void put_member();
        int k;
        int n;
        int r;
        r = $urandom_range(0, 19);
        if (r < 12) begin
            k = $urandom_range(0, 3);
            put("\""); put(key_name[k]); put("\""); put_space(); put(":"); put_space();
            case ($urandom_range(0, 19))
                0: n = TARGET_CAP[k] - $urandom_range(1, 2);
                1: n = -1;
                default: n = $urandom_range(0, 8);
            endcase
            if (n < 0) put_value(1);
            else begin
                put("\""); put_chars(n, $urandom_range(0, 9) == 0); put("\"");
            end
        end else begin
            put("\"");
            case (r)
                12: repeat (KEY_LIMIT - 1 + $urandom_range(0, 1)) put("a");
                13: begin put("id"); put("\\t"); end
                14: put(key_name[$urandom_range(0, 3)].substr(0, 0));
                default: put_chars($urandom_range(1, 6), 1'b0);
            endcase
            put("\""); put_space(); put(":"); put_space();
            if ($urandom_range(0, 29) == 0) begin
                // run the nest right up to the depth limit, sometimes past it
                n = $urandom_range(DEPTH_MAX - 3, DEPTH_MAX + 1);
                repeat (n) put("[");
                put("7");
                repeat (n) put("]");
            end else put_value(1);
        end
    endfunction

    function automatic void add_manifest();
        int n;
        int pos;
        text.delete();
        if ($urandom_range(0, 24) == 0) begin
            add_request(8'($urandom), 1'b0, 1'b1);
            return;
        end
        put_space(); put("{"); put_space();
        n = $urandom_range(0, 4);
        for (int i = 0; i < n; i++) begin
            if (i > 0) put(",");
            put_space(); put_member(); put_space();
        end
        put("}"); put_space();
        // break one in four
        if ($urandom_range(0, 3) == 0) begin
            pos = $urandom_range(0, text.size() - 1);
            text[pos] = 8'($urandom);
        end
        if ($urandom_range(0, 9) == 0) begin
            pos = $urandom_range(0, text.size() - 1);
            while (text.size() > pos) void'(text.pop_back());
        end
        foreach (text[i]) begin
            if ($urandom_range(0, 19) == 0) add_request(8'($urandom), 1'b0, 1'b0);
            add_request(text[i], 1'b1, (i == text.size() - 1) && $urandom_range(0, 1));
        end
        if (requests.size() == 0 || !requests[$].last) add_request(8'($urandom), 1'b0, 1'b1);
    endfunction

    function automatic int gap_len();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report(string field, int got, int want);
        $display("mismatch %s: got %0h expected %0h (result %0d)", field, got, want,
                 results_seen);
        errors++;
    endtask

    // accept requests and check results
    always @(posedge i_clk) begin
        t_request q;
        t_result e;
        t_result p;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                q = issued.pop_front();
                p = validate_step(in_ch.data_byte, in_ch.byte_present, in_ch.last);
                expected_results.push_back(q.typed ? q.exp : p);
            end
            if (out_ch.valid && out_ch.ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    report("unexpected result", 0, 0);
                end else begin
                    e = expected_results.pop_front();
                    if (out_ch.capture_valid !== e.cap_valid)
                        report("capture_valid", out_ch.capture_valid, e.cap_valid);
                    if (out_ch.capture_target !== e.cap_target)
                        report("capture_target", out_ch.capture_target, e.cap_target);
                    if (out_ch.capture_byte !== e.cap_byte)
                        report("capture_byte", out_ch.capture_byte, e.cap_byte);
                    if (out_ch.done_res !== e.done)
                        report("done_res", out_ch.done_res, e.done);
                    if (out_ch.accepted !== e.accepted)
                        report("accepted", out_ch.accepted, e.accepted);
                    if (out_ch.present_mask !== e.mask)
                        report("present_mask", out_ch.present_mask, e.mask);
                end
            end
        end
    end

    // receiver stalls, with one long hold-off to back the block up
    int  ready_hold;
    bit  pressed;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if (!pressed && results_seen >= 300) begin
            pressed <= 1'b1;
            out_ch.ready <= 1'b0;
            ready_hold <= 400;
        end else if (out_ch.ready && $urandom_range(0, 99) < 30) begin
            out_ch.ready <= 1'b0;
            ready_hold <= gap_len();
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // alternate busy and quiet stretches
    always @(posedge i_clk) begin
        if ($urandom_range(0, 199) == 0) calm <= ~calm;
    end

    int idle_cycles;
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        int g;
        int wait_cycles;
        in_ch.valid = 1'b0;
        in_ch.data_byte = 8'h00;
        in_ch.byte_present = 1'b0;
        in_ch.last = 1'b0;
        out_ch.ready = 1'b0;
        i_rst_n = 1'b0;
        errors = 0;
        results_seen = 0;
        calm = 1'b0;
        ready_hold = 0;
        pressed = 1'b0;
        idle_cycles = 0;
        clear_parser();

        // empty manifest, absent byte, whitespace alone, bad first byte
        add_request(8'h00, 1'b0, 1'b1, 1'b1, verdict(4'h0, 1'b1));
        add_request(8'hA5, 1'b0, 1'b0, 1'b1, '0);
        add_request(8'h20, 1'b1, 1'b0);
        add_request(8'h00, 1'b0, 1'b1, 1'b1, verdict(4'h0, 1'b0));
        add_request("x", 1'b1, 1'b1, 1'b1, verdict(4'h0, 1'b0));
        // id value with a top-bit byte
        put("{\"id\":\""); text.push_back(8'hFF); put("\"}");
        foreach (text[i]) add_request(text[i], 1'b1, 1'b0);
        add_request(8'h00, 1'b0, 1'b1, 1'b1, verdict(4'h2, 1'b1));
        // control byte in a key
        add_request("{", 1'b1, 1'b0);
        add_request(QUOTE, 1'b1, 1'b0);
        add_request(8'h00, 1'b1, 1'b1, 1'b1, verdict(4'h0, 1'b0));
        while (requests.size() < 1420) add_manifest();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (requests[i]) begin
            g = gap_len();
            if (g > 0) begin
                in_ch.valid <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
            in_ch.valid <= 1'b1;
            in_ch.data_byte <= requests[i].data;
            in_ch.byte_present <= requests[i].present;
            in_ch.last <= requests[i].last;
            issued.push_back(requests[i]);
            @(posedge i_clk);
            while (!in_ch.ready) @(posedge i_clk);
        end
        in_ch.valid <= 1'b0;

        wait_cycles = 0;
        while (expected_results.size() > 0 && wait_cycles < 20000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (10) @(posedge i_clk);
        if (expected_results.size() > 0) report("results missing", 0, expected_results.size());

        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
rtl/jmsv_pkg.sv
rtl/jmsv_if.sv
rtl/jmsv_front.sv
rtl/jmsv_queue.sv
rtl/jmsv_back.sv
rtl/json_manifest_stream_validator.sv
bench/tb_json_manifest_stream_validator.sv
